// ----- rtl/calendar_to_gps_time_unit_assert.svh -----
// Assertion macros shared by the conversion unit.
`ifndef CALENDAR_TO_GPS_TIME_UNIT_ASSERT_SVH
`define CALENDAR_TO_GPS_TIME_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define CGT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons starting in the cycle after ante.
`define CGT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cgt_pkg.sv -----
package cgt_pkg;

    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 6;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SEC_W    = 26;
    localparam int unsigned LEAP_W   = 6;
    localparam int unsigned WEEK_W   = 17;
    localparam int unsigned WSEC_W   = 40;

    localparam int unsigned DCNT_W   = 20;
    localparam int unsigned DSGN_W   = 22;
    localparam int unsigned SOD_W    = 37;

    localparam logic [LEAP_W-1:0] LEAP_RESET = LEAP_W'(18);

    localparam logic [SOD_W-1:0] US_PER_SEC  = SOD_W'(64'd1000000);
    localparam logic [SOD_W-1:0] US_PER_MIN  = SOD_W'(64'd60000000);
    localparam logic [SOD_W-1:0] US_PER_HOUR = SOD_W'(64'd3600000000);
    localparam logic [SOD_W-1:0] US_PER_DAY  = SOD_W'(64'd86400000000);
    localparam logic [WSEC_W-1:0] US_PER_WEEK = WSEC_W'(64'd604800000000);

    localparam logic [SEC_W-1:0]    SEC_MAX    = SEC_W'(60000000);
    localparam logic [DAY_W-1:0]    DAY_MAX    = DAY_W'(31);
    localparam logic [HOUR_W-1:0]   HOUR_MAX   = HOUR_W'(24);
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = MINUTE_W'(60);
    localparam logic [MONTH_W-1:0]  MONTH_FEB  = MONTH_W'(2);

    // 2400000 - 1720981 + 44244: rebase to MJD and then to the GPS epoch
    localparam logic [DSGN_W-1:0] EPOCH_OFFSET = DSGN_W'(723263);

    localparam logic [23:0] YEAR_DAYS_X4 = 24'd1461;

    // floor(2^23 / 7) + 1, exact for dividends below 2^21
    localparam int unsigned        DIV7_SHIFT = 23;
    localparam int unsigned        DIV7_PROD_W = 41;
    localparam logic [DIV7_PROD_W-1:0] DIV7_RECIP = DIV7_PROD_W'(1198373);
    localparam logic [DCNT_W-1:0]  DAYS_PER_WEEK = DCNT_W'(7);

    function automatic logic [8:0] month_days(input logic [MONTH_W-1:0] month);
        logic [8:0] days;
        unique case (month)
            4'd0:    days = 9'd397;
            4'd1:    days = 9'd428;
            4'd2:    days = 9'd459;
            4'd3:    days = 9'd122;
            4'd4:    days = 9'd153;
            4'd5:    days = 9'd183;
            4'd6:    days = 9'd214;
            4'd7:    days = 9'd244;
            4'd8:    days = 9'd275;
            4'd9:    days = 9'd306;
            4'd10:   days = 9'd336;
            4'd11:   days = 9'd367;
            4'd12:   days = 9'd397;
            4'd13:   days = 9'd428;
            4'd14:   days = 9'd459;
            default: days = 9'd489;
        endcase
        return days;
    endfunction

    function automatic logic [WSEC_W-1:0] weekday_us(input logic [2:0] wday);
        logic [WSEC_W-1:0] us;
        unique case (wday)
            3'd0:    us = WSEC_W'(64'd0);
            3'd1:    us = WSEC_W'(64'd86400000000);
            3'd2:    us = WSEC_W'(64'd172800000000);
            3'd3:    us = WSEC_W'(64'd259200000000);
            3'd4:    us = WSEC_W'(64'd345600000000);
            3'd5:    us = WSEC_W'(64'd432000000000);
            3'd6:    us = WSEC_W'(64'd518400000000);
            default: us = WSEC_W'(64'd0);
        endcase
        return us;
    endfunction

endpackage

// ----- rtl/cgt_div7.sv -----
module cgt_div7 (
    input  logic                         i_clk,
    input  logic [cgt_pkg::DCNT_W-1:0]   i_dividend,
    output logic [cgt_pkg::WEEK_W-1:0]   o_quotient
);

    logic [cgt_pkg::DIV7_PROD_W-1:0] n_prod;
    logic [cgt_pkg::WEEK_W-1:0]      r_quotient;

    assign n_prod = cgt_pkg::DIV7_PROD_W'(i_dividend) * cgt_pkg::DIV7_RECIP;

    always_ff @(posedge i_clk) begin
        r_quotient <= n_prod[cgt_pkg::DIV7_SHIFT +: cgt_pkg::WEEK_W];
    end

    assign o_quotient = r_quotient;

endmodule

// ----- rtl/calendar_to_gps_time_unit.sv -----
// Channel   Strobe     Fields
// -------   ------     ------
// command   start      i_year i_month i_day i_hour i_minute i_second_us
// result    o_done     o_gps_week o_week_second_us o_valid_res
// config    i_cfg_we   i_cfg_data (leap seconds)
//
// One word accepted every cycle; busy stays low.
// Each result is formed by a four-stage pipe (date sum, day carry, divide-by-seven
// multiply, week-second add) plus input register.
// Synchronous active-low reset clears stage valids and sets leap seconds to 18.
// The receiver cannot stall: o_done marks each result for exactly one cycle.
`include "calendar_to_gps_time_unit_assert.svh"

module calendar_to_gps_time_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [cgt_pkg::YEAR_W-1:0]       i_year,
    input  logic [cgt_pkg::MONTH_W-1:0]      i_month,
    input  logic [cgt_pkg::DAY_W-1:0]        i_day,
    input  logic [cgt_pkg::HOUR_W-1:0]       i_hour,
    input  logic [cgt_pkg::MINUTE_W-1:0]     i_minute,
    input  logic [cgt_pkg::SEC_W-1:0]        i_second_us,
    input  logic                             i_cfg_we,
    input  logic [cgt_pkg::LEAP_W-1:0]       i_cfg_data,
    output logic                             o_done,
    output logic [cgt_pkg::WEEK_W-1:0]       o_gps_week,
    output logic [cgt_pkg::WSEC_W-1:0]       o_week_second_us,
    output logic                             o_valid_res
);

    localparam int unsigned DW = cgt_pkg::DSGN_W;

    logic [cgt_pkg::LEAP_W-1:0]   r_leap;

    logic                         r_v0;
    logic [cgt_pkg::YEAR_W-1:0]   r_year;
    logic [cgt_pkg::MONTH_W-1:0]  r_month;
    logic [cgt_pkg::DAY_W-1:0]    r_day;
    logic [cgt_pkg::HOUR_W-1:0]   r_hour;
    logic [cgt_pkg::MINUTE_W-1:0] r_minute;
    logic [cgt_pkg::SEC_W-1:0]    r_sec;
    logic [cgt_pkg::LEAP_W-1:0]   r_leap0;

    logic                         r_v1;
    logic                         r_ok1;
    logic signed [DW-1:0]         r_dd1;
    logic [cgt_pkg::SOD_W-1:0]    r_sod1;

    logic                         r_v2;
    logic                         r_ok2;
    logic [cgt_pkg::DCNT_W-1:0]   r_d2;
    logic [cgt_pkg::SOD_W-1:0]    r_sod2;

    logic                         r_v3;
    logic                         r_ok3;
    logic [cgt_pkg::DCNT_W-1:0]   r_d3;
    logic [cgt_pkg::SOD_W-1:0]    r_sod3;
    logic [cgt_pkg::WEEK_W-1:0]   w_q3;

    logic                         r_done;
    logic [cgt_pkg::WEEK_W-1:0]   r_gps_week;
    logic [cgt_pkg::WSEC_W-1:0]   r_wsec;
    logic                         r_valid_res;

    logic signed [12:0]           n_y;
    logic signed [23:0]           n_prod;
    logic signed [23:0]           n_yd;
    logic signed [DW-1:0]         n_dd1;
    logic [cgt_pkg::SOD_W-1:0]    n_sod1;
    logic                         n_ok1;

    logic                         n_carry;
    logic [cgt_pkg::SOD_W-1:0]    n_sod2;
    logic signed [DW-1:0]         n_dd2;
    logic                         n_ok2;

    logic [cgt_pkg::DCNT_W-1:0]   n_rem_full;
    logic [2:0]                   n_wday;
    logic [cgt_pkg::WSEC_W-1:0]   n_wsec;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leap <= cgt_pkg::LEAP_RESET;
        end else if (i_cfg_we) begin
            r_leap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v0   <= start && !busy;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_year   <= i_year;
        r_month  <= i_month;
        r_day    <= i_day;
        r_hour   <= i_hour;
        r_minute <= i_minute;
        r_sec    <= i_second_us;
        r_leap0  <= r_leap;
    end

    always_comb begin
        n_y = $signed({1'b0, r_year}) - ((r_month <= cgt_pkg::MONTH_FEB) ? 13'sd1 : 13'sd0);
        n_prod = 24'(n_y) * $signed(cgt_pkg::YEAR_DAYS_X4);
        n_yd = n_prod >>> 2;
        n_dd1 = DW'(n_yd)
              + $signed(DW'(cgt_pkg::month_days(r_month)))
              + $signed(DW'(r_day))
              - $signed(cgt_pkg::EPOCH_OFFSET);
        n_sod1 = cgt_pkg::SOD_W'(r_hour) * cgt_pkg::US_PER_HOUR
               + cgt_pkg::SOD_W'(r_minute) * cgt_pkg::US_PER_MIN
               + cgt_pkg::SOD_W'(r_sec)
               + cgt_pkg::SOD_W'(r_leap0) * cgt_pkg::US_PER_SEC;
        n_ok1 = (r_day <= cgt_pkg::DAY_MAX) && (r_hour <= cgt_pkg::HOUR_MAX)
             && (r_minute <= cgt_pkg::MINUTE_MAX) && (r_sec <= cgt_pkg::SEC_MAX);
    end

    always_ff @(posedge i_clk) begin
        r_dd1  <= n_dd1;
        r_sod1 <= n_sod1;
        r_ok1  <= n_ok1;
    end

    always_comb begin
        n_carry = (r_sod1 >= cgt_pkg::US_PER_DAY);
        n_sod2  = n_carry ? (r_sod1 - cgt_pkg::US_PER_DAY) : r_sod1;
        n_dd2   = r_dd1 + $signed(DW'(n_carry));
        n_ok2   = r_ok1 && !n_dd2[DW-1];
    end

    // zero the payload of invalid words so week and seconds read as zero
    always_ff @(posedge i_clk) begin
        r_ok2  <= n_ok2;
        r_d2   <= n_ok2 ? n_dd2[cgt_pkg::DCNT_W-1:0] : '0;
        r_sod2 <= n_ok2 ? n_sod2 : '0;
    end

    cgt_div7 u_div7 (
        .i_clk      (i_clk),
        .i_dividend (r_d2),
        .o_quotient (w_q3)
    );

    always_ff @(posedge i_clk) begin
        r_ok3  <= r_ok2;
        r_d3   <= r_d2;
        r_sod3 <= r_sod2;
    end

    always_comb begin
        n_rem_full = r_d3 - cgt_pkg::DCNT_W'(cgt_pkg::DCNT_W'(w_q3) * cgt_pkg::DAYS_PER_WEEK);
        n_wday     = n_rem_full[2:0];
        n_wsec     = cgt_pkg::weekday_us(n_wday) + cgt_pkg::WSEC_W'(r_sod3);
    end

    always_ff @(posedge i_clk) begin
        r_gps_week  <= w_q3;
        r_wsec      <= n_wsec;
        r_valid_res <= r_ok3;
    end

    assign o_done           = r_done;
    assign o_gps_week       = r_gps_week;
    assign o_week_second_us = r_wsec;
    assign o_valid_res      = r_valid_res;

    `CGT_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, o_done && !o_valid_res, o_gps_week == '0 && o_week_second_us == '0, "invalid result carries nonzero payload")
    `CGT_ASSERT_NOW(a_wsec_range, i_clk, i_rst_n, o_done && o_valid_res, o_week_second_us < cgt_pkg::US_PER_WEEK, "week second out of range")
    `CGT_ASSERT_NOW(a_latency, i_clk, i_rst_n, start && !busy, ##5 o_done, "result strobe missing after accept")
    `CGT_ASSERT_NEXT(a_no_ghost, i_clk, i_rst_n, !r_v3, !o_done, "result strobe without a word in flight")

endmodule

// ----- tb/calendar_to_gps_time_unit_tb.sv -----
module calendar_to_gps_time_unit_tb;

    localparam int unsigned YEAR_W   = cgt_pkg::YEAR_W;
    localparam int unsigned MONTH_W  = cgt_pkg::MONTH_W;
    localparam int unsigned DAY_W    = cgt_pkg::DAY_W;
    localparam int unsigned HOUR_W   = cgt_pkg::HOUR_W;
    localparam int unsigned MINUTE_W = cgt_pkg::MINUTE_W;
    localparam int unsigned SEC_W    = cgt_pkg::SEC_W;
    localparam int unsigned LEAP_W   = cgt_pkg::LEAP_W;
    localparam int unsigned WEEK_W   = cgt_pkg::WEEK_W;
    localparam int unsigned WSEC_W   = cgt_pkg::WSEC_W;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_WORDS = 330;
    localparam int MAX_SHOWN    = 10;

    localparam longint USEC_PER_SEC  = 64'd1000000;
    localparam longint USEC_PER_MIN  = 64'd60000000;
    localparam longint USEC_PER_HOUR = 64'd3600000000;
    localparam longint USEC_PER_DAY  = 64'd86400000000;
    localparam longint JD_BASE       = 1720981;
    localparam longint MJD_BASE      = 2400000;
    localparam longint EPOCH_MJD     = 44244;
    localparam longint DAYS_IN_WEEK  = 7;
    localparam longint LAST_DAY      = 31;
    localparam longint LAST_HOUR     = 24;
    localparam longint LAST_MINUTE   = 60;
    localparam longint LAST_SEC_US   = 60000000;
    localparam int     LEAP_DEFAULT  = 18;

    localparam int MONTH_TERM [16] = '{
        397, 428, 459, 122, 153, 183, 214, 244,
        275, 306, 336, 367, 397, 428, 459, 489
    };

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SEC_W-1:0]    second_us;
    } t_cal_word;

    typedef struct packed {
        logic [WEEK_W-1:0] week;
        logic [WSEC_W-1:0] wsec;
        logic              valid;
    } t_gps_time;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [YEAR_W-1:0]   i_year;
    logic [MONTH_W-1:0]  i_month;
    logic [DAY_W-1:0]    i_day;
    logic [HOUR_W-1:0]   i_hour;
    logic [MINUTE_W-1:0] i_minute;
    logic [SEC_W-1:0]    i_second_us;
    logic                i_cfg_we;
    logic [LEAP_W-1:0]   i_cfg_data;
    logic                o_done;
    logic [WEEK_W-1:0]   o_gps_week;
    logic [WSEC_W-1:0]   o_week_second_us;
    logic                o_valid_res;

    t_gps_time         pending_gps_q[$];
    logic [LEAP_W-1:0] leap_s;
    int                fail_count;
    int                shown_count;
    int                idle_pct;
    int                cycles;

    calendar_to_gps_time_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_year           (i_year),
        .i_month          (i_month),
        .i_day            (i_day),
        .i_hour           (i_hour),
        .i_minute         (i_minute),
        .i_second_us      (i_second_us),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_gps_week       (o_gps_week),
        .o_week_second_us (o_week_second_us),
        .o_valid_res      (o_valid_res)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_gps_time gps_time_of(input t_cal_word w, input logic [LEAP_W-1:0] leap);
        t_gps_time r;
        longint    y;
        longint    prod;
        longint    mjd;
        longint    sod;
        longint    d;
        logic      ok;
        ok = (w.day <= LAST_DAY) && (w.hour <= LAST_HOUR) && (w.minute <= LAST_MINUTE) &&
             (w.second_us <= LAST_SEC_US);
        y = (w.month <= 2) ? longint'(w.year) - 1 : longint'(w.year);
        prod = 1461 * y;
        mjd = (prod >= 0) ? prod / 4 : -((-prod + 3) / 4);
        mjd = mjd + MONTH_TERM[w.month] + longint'(w.day) + JD_BASE - MJD_BASE;
        sod = longint'(w.hour) * USEC_PER_HOUR + longint'(w.minute) * USEC_PER_MIN +
              longint'(w.second_us) + longint'(leap) * USEC_PER_SEC;
        if (sod >= USEC_PER_DAY) begin
            mjd = mjd + 1;
            sod = sod - USEC_PER_DAY;
        end
        d = mjd - EPOCH_MJD;
        if (d < 0)
            ok = 1'b0;
        r = '0;
        if (ok) begin
            r.week = WEEK_W'(d / DAYS_IN_WEEK);
            r.wsec = WSEC_W'((d % DAYS_IN_WEEK) * USEC_PER_DAY + sod);
        end
        r.valid = ok;
        return r;
    endfunction

    function automatic t_cal_word cal(input int y, input int mo, input int d, input int h,
                                      input int mi, input int s_us);
        t_cal_word w;
        w.year      = YEAR_W'(y);
        w.month     = MONTH_W'(mo);
        w.day       = DAY_W'(d);
        w.hour      = HOUR_W'(h);
        w.minute    = MINUTE_W'(mi);
        w.second_us = SEC_W'(s_us);
        return w;
    endfunction

    function automatic t_cal_word rand_word();
        t_cal_word w;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            w = cal(1980, 1, $urandom_range(7, 5), $urandom_range(23, 0),
                    $urandom_range(59, 0), $urandom_range(59999999, 0));
        end else if (pick < 80) begin
            w = cal($urandom_range(2200, 1979), $urandom_range(12, 1), $urandom_range(31, 1),
                    $urandom_range(23, 0), $urandom_range(59, 0), $urandom_range(59999999, 0));
        end else if (pick < 88) begin
            w = cal($urandom_range(2100, 1980), $urandom_range(12, 1), $urandom_range(31, 0),
                    $urandom_range(24, 20), $urandom_range(60, 55),
                    $urandom_range(60000000, 55000000));
        end else begin
            w = cal($urandom_range(4095, 0), $urandom_range(15, 0), $urandom_range(63, 0),
                    $urandom_range(31, 0), $urandom_range(63, 0),
                    $urandom_range((1 << SEC_W) - 1, 0));
        end
        return w;
    endfunction

    task automatic send_word(input t_cal_word w);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start       = 1'b1;
        i_year      = w.year;
        i_month     = w.month;
        i_day       = w.day;
        i_hour      = w.hour;
        i_minute    = w.minute;
        i_second_us = w.second_us;
        do @(posedge i_clk); while (busy);
        pending_gps_q.push_back(gps_time_of(w, leap_s));
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_gps_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_leap(input logic [LEAP_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        leap_s   = value;
    endtask

    task automatic test_field_limits();
        send_word(cal(0, 0, 0, 0, 0, 0));
        send_word(cal(0, 1, 1, 0, 0, 0));
        send_word(cal(2024, 6, 15, 12, 34, 56789012));
        send_word(cal(2100, 12, 31, 24, 60, 60000000));
        send_word(cal(2100, 12, 32, 0, 0, 0));
        send_word(cal(2100, 12, 1, 25, 0, 0));
        send_word(cal(2100, 12, 1, 0, 61, 0));
        send_word(cal(2100, 12, 1, 0, 0, 60000001));
        send_word(cal(4095, 15, 63, 31, 63, (1 << SEC_W) - 1));
        send_word(cal(4095, 15, 31, 23, 59, 59999999));
        send_word(cal(2023, 2, 31, 10, 0, 0));
    endtask

    task automatic test_month_codes();
        for (int mo = 0; mo < 16; mo++)
            send_word(cal(2001, mo, 10, 6, 30, 15000000));
    endtask

    task automatic test_epoch_edge();
        send_word(cal(1980, 1, 6, 0, 0, 0));
        send_word(cal(1980, 1, 5, 23, 59, 42000000));
        send_word(cal(1980, 1, 5, 23, 59, 41999999));
        send_word(cal(1980, 1, 1, 12, 0, 0));
        send_word(cal(1979, 12, 31, 23, 59, 59999999));
        send_word(cal(1980, 1, 12, 23, 59, 59999999));
    endtask

    task automatic test_leap_extremes();
        write_leap(LEAP_W'(0));
        send_word(cal(1980, 1, 6, 0, 0, 0));
        send_word(cal(1980, 1, 5, 23, 59, 59999999));
        send_word(cal(2015, 6, 30, 23, 59, 60000000));
        send_word(cal(2100, 12, 31, 24, 60, 60000000));
        write_leap(LEAP_W'((1 << LEAP_W) - 1));
        send_word(cal(1980, 1, 5, 23, 58, 57000000));
        send_word(cal(1980, 1, 5, 23, 58, 56999999));
        send_word(cal(2100, 12, 31, 24, 60, 60000000));
        send_word(cal(1980, 1, 12, 23, 59, 0));
    endtask

    task automatic test_random();
        logic [LEAP_W-1:0] leap_plan [5];
        leap_plan = '{LEAP_W'(LEAP_DEFAULT), LEAP_W'(0), LEAP_W'((1 << LEAP_W) - 1),
                      LEAP_W'($urandom_range(62, 1)), LEAP_W'($urandom_range(62, 1))};
        foreach (leap_plan[p]) begin
            write_leap(leap_plan[p]);
            idle_pct = (p == 1) ? 0 : 8;
            repeat (RANDOM_WORDS) send_word(rand_word());
        end
        idle_pct = 8;
    endtask

    always @(posedge i_clk) begin
        t_gps_time want;
        if (i_rst_n && o_done) begin
            if (pending_gps_q.size() == 0) begin
                fail_count++;
                if (shown_count < MAX_SHOWN) begin
                    shown_count++;
                    $display("unexpected word: week %0d wsec %0d valid %0d",
                             o_gps_week, o_week_second_us, o_valid_res);
                end
            end else begin
                want = pending_gps_q.pop_front();
                if (o_gps_week !== want.week || o_week_second_us !== want.wsec ||
                    o_valid_res !== want.valid) begin
                    fail_count++;
                    if (shown_count < MAX_SHOWN) begin
                        shown_count++;
                        $display("mismatch: week %0d/%0d wsec %0d/%0d valid %0d/%0d (exp/act)",
                                 want.week, o_gps_week, want.wsec, o_week_second_us,
                                 want.valid, o_valid_res);
                    end
                end
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_year      = '0;
        i_month     = '0;
        i_day       = '0;
        i_hour      = '0;
        i_minute    = '0;
        i_second_us = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        fail_count  = 0;
        shown_count = 0;
        idle_pct    = 8;
        leap_s      = LEAP_W'(LEAP_DEFAULT);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_field_limits();
        test_month_codes();
        test_epoch_edge();
        test_leap_extremes();
        test_random();
        drain();

        if (fail_count == 0 && pending_gps_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cgt_pkg.sv
rtl/cgt_div7.sv
rtl/calendar_to_gps_time_unit.sv
tb/calendar_to_gps_time_unit_tb.sv
